[rtl/hrr_pkg.sv]
`timescale 1ns / 1ps
package hrr_pkg;

    // default sizes of the sample store and the position fraction
    localparam int FRAME_ADDR_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF       = 16;

    // field widths
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 24;
    localparam int COUNT_W  = 16;
    localparam int TRACK_W  = 17;
    localparam int GAIN_W   = 16;
    localparam int POSF_W   = 17;

    // stream widths
    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 56;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_TRACK_FRAMES = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_ENABLE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_START   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_END     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_RATE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_GAIN     = 3'd5;

    // operations
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RAMP   = 2'd1;
    localparam logic [OP_W-1:0] OP_RENDER = 2'd2;
    localparam logic [OP_W-1:0] OP_SEEK   = 2'd3;

endpackage

[rtl/hrr_ram.sv]
`timescale 1ns / 1ps
module hrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/hermite_resampler_with_ramp.sv]
`timescale 1ns / 1ps
// Stereo 4-point Hermite resampler with velocity and nudge ramps. Input items
// carry an op in s_tuser: write one frame into the sample store, start a ramp
// (two 24-step restoring divisions on one shared divider), render one frame
// (four reads from the single-port sample store, then per channel a
// coefficient step and four passes through one shared multiplier, then the
// position advance; a render at the end of the track without looping returns
// silence), or seek. Only a render returns a result on the m_ side. One item
// is worked on at a time and s_tready is low meanwhile. The user must write
// registers through cfg_we/cfg_addr/cfg_wdata only while the block is idle;
// the block itself does not enforce it. The sample store holds no reset value;
// render only frames that were written.
module hermite_resampler_with_ramp #(
    parameter int FRAME_ADDR_BITS = hrr_pkg::FRAME_ADDR_BITS_DEF,
    parameter int FRAC_BITS       = hrr_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hrr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hrr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frame_addr, sample_left, sample_right, start_velocity, target_velocity,
    // nudge_begin, nudge_end, frame_count
    input  logic [hrr_pkg::S_TDATA_W-1:0]  s_tdata,
    // op
    input  logic [hrr_pkg::OP_W-1:0]       s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_left, out_right, is_playing, position_frame, zero fill
    output logic [hrr_pkg::M_TDATA_W-1:0]  m_tdata
);
    import hrr_pkg::*;

    localparam int A     = FRAME_ADDR_BITS;
    localparam int F     = FRAC_BITS;
    localparam int DEPTH = 1 << A;
    localparam int PW    = A + 1 + F;
    localparam int IW    = A + 1;
    localparam int EW    = (IW > TRACK_W) ? IW : TRACK_W;
    localparam int MA    = 24;
    localparam int MB    = (F > 16) ? F : 16;
    localparam int PR    = MA + MB + 1;
    localparam int SW    = PW + 2;
    localparam int SHL   = (F >= 16) ? F - 16 : 0;
    localparam int SHR   = (F < 16) ? 16 - F : 0;
    localparam int DIV_N = 24;
    localparam int SUMW  = RATE_W + 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_COEF = 4'd2;
    localparam logic [3:0] S_M1   = 4'd3;
    localparam logic [3:0] S_M2   = 4'd4;
    localparam logic [3:0] S_M3   = 4'd5;
    localparam logic [3:0] S_M4   = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_ADV  = 4'd8;
    localparam logic [3:0] S_OUTW = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;

    // input fields
    logic [ADDR_W-1:0]   in_addr;
    logic [SAMPLE_W-1:0] in_left, in_right;
    logic [RATE_W-1:0]   in_sv, in_tv, in_sn, in_tn;
    logic [COUNT_W-1:0]  in_count;

    assign in_addr  = s_tdata[15:0];
    assign in_left  = s_tdata[31:16];
    assign in_right = s_tdata[47:32];
    assign in_sv    = s_tdata[71:48];
    assign in_tv    = s_tdata[95:72];
    assign in_sn    = s_tdata[119:96];
    assign in_tn    = s_tdata[143:120];
    assign in_count = s_tdata[159:144];

    // configuration
    logic [TRACK_W-1:0] track_reg, loop_end_reg;
    logic               loop_en_reg;
    logic [ADDR_W-1:0]  loop_start_reg;
    logic [RATE_W-1:0]  pitch_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // state
    logic [3:0]          state_reg;
    logic [PW-1:0]       pos_reg;
    logic [RATE_W-1:0]   cur_v_reg, cur_n_reg;
    logic [RATE_W:0]     vstep_reg, nstep_reg;
    logic                playing_reg;

    logic [A-1:0]        rd_addr_reg [4];
    logic [31:0]         p_reg [4];
    logic [2:0]          rd_cnt_reg;
    logic [F-1:0]        f_reg;
    logic                ch_reg;
    logic signed [MA-1:0] c1_reg, c2_reg, c3_reg, tp1_reg;
    logic signed [PR-1:0] prod_reg;
    logic [SAMPLE_W-1:0] res_l_reg, res_r_reg;

    logic [15:0]         div_rem_reg, div_n_reg;
    logic [DIV_N-1:0]    div_quo_reg;
    logic [4:0]          div_cnt_reg;
    logic                div_neg_reg, div_sel_reg;
    logic [RATE_W:0]     dn_diff_reg;

    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // sample store
    logic          ram_we;
    logic [A-1:0]  ram_addr;
    logic [31:0]   ram_rdata;
    logic [ADDR_W+A-1:0] in_addr_wide;

    assign in_addr_wide = {{A{1'b0}}, in_addr};
    assign ram_we   = accept && (s_tuser == OP_WRITE);
    assign ram_addr = (state_reg == S_IDLE) ? in_addr_wide[A-1:0] : rd_addr_reg[rd_cnt_reg[1:0]];

    hrr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({in_right, in_left}),
        .rdata (ram_rdata)
    );

    // render setup: end of track, loop wrap and clamped neighbors
    logic [TRACK_W-1:0] end_sel;
    logic [EW-1:0]      end_e, sel_e, ls_e;
    logic [IW-1:0]      end_w, idx_w, ls_w, base_idx, i0_w, i2_w, i3_w;
    logic [F-1:0]       frac_w, base_f;
    logic               past_end;

    always_comb begin
        end_sel = loop_en_reg ? loop_end_reg : track_reg;
        sel_e   = EW'(end_sel);
        if (sel_e == '0) begin
            end_e = EW'(1);
        end else if (sel_e > EW'(DEPTH)) begin
            end_e = EW'(DEPTH);
        end else begin
            end_e = sel_e;
        end
        end_w    = end_e[IW-1:0];
        idx_w    = pos_reg[PW-1:F];
        frac_w   = pos_reg[F-1:0];
        past_end = (idx_w >= end_w);
        ls_e     = EW'(loop_start_reg);
        ls_w     = (ls_e >= end_e) ? end_w - IW'(1) : ls_e[IW-1:0];
        base_idx = past_end ? ls_w : idx_w;
        base_f   = past_end ? '0 : frac_w;
        i0_w     = (base_idx != '0) ? base_idx - IW'(1) : '0;
        i2_w     = (base_idx + IW'(1) < end_w) ? base_idx + IW'(1) : end_w - IW'(1);
        i3_w     = (base_idx + IW'(2) < end_w) ? base_idx + IW'(2) : end_w - IW'(1);
    end

    // seek target
    logic [EW-1:0] seek_e;
    logic [IW-1:0] seek_w;
    assign seek_e = EW'(in_addr);
    assign seek_w = seek_e[IW-1:0];

    // samples of the current channel
    logic signed [MA-1:0] s0, s1, s2, s3;
    always_comb begin
        if (ch_reg) begin
            s0 = MA'($signed(p_reg[0][31:16]));
            s1 = MA'($signed(p_reg[1][31:16]));
            s2 = MA'($signed(p_reg[2][31:16]));
            s3 = MA'($signed(p_reg[3][31:16]));
        end else begin
            s0 = MA'($signed(p_reg[0][15:0]));
            s1 = MA'($signed(p_reg[1][15:0]));
            s2 = MA'($signed(p_reg[2][15:0]));
            s3 = MA'($signed(p_reg[3][15:0]));
        end
    end

    // shared multiplier
    logic signed [PR-1:0] shr_full, rnd_full;
    logic signed [MA-1:0] shr_t, mul_a;
    logic [MB-1:0]        mul_b;
    logic [SAMPLE_W-1:0]  y_sat;

    assign shr_full = prod_reg >>> F;
    assign shr_t    = shr_full[MA-1:0];
    assign rnd_full = (prod_reg + PR'(16384)) >>> 15;

    always_comb begin
        mul_a = c3_reg;
        mul_b = MB'(f_reg);
        case (state_reg)
            S_M2: mul_a = shr_t + c2_reg;
            S_M3: mul_a = shr_t + c1_reg;
            S_M4: begin
                mul_a = shr_t + tp1_reg;
                mul_b = MB'(gain_reg);
            end
            default: mul_a = c3_reg;
        endcase
        if (rnd_full > PR'(32767)) begin
            y_sat = 16'h7fff;
        end else if (rnd_full < -PR'(32768)) begin
            y_sat = 16'h8000;
        end else begin
            y_sat = rnd_full[SAMPLE_W-1:0];
        end
    end

    // position advance
    logic signed [SUMW-1:0] rate_sum;
    logic signed [SW-1:0]   step_ext, step_sh, pos_sum;
    logic [PW-1:0]          pos_adv;
    logic signed [SUMW-1:0] v_sum, n_sum;
    logic [RATE_W-1:0]      v_sat, n_sat;

    always_comb begin
        rate_sum = SUMW'($signed(pitch_reg)) + SUMW'($signed(cur_n_reg))
                 + SUMW'($signed(cur_v_reg));
        step_ext = SW'(rate_sum);
        if (F >= 16) begin
            step_sh = step_ext <<< SHL;
        end else begin
            step_sh = step_ext >>> SHR;
        end
        pos_sum = $signed({2'b00, pos_reg}) + step_sh;
        if (pos_sum[SW-1]) begin
            pos_adv = '0;
        end else if (pos_sum[SW-2]) begin
            pos_adv = '1;
        end else begin
            pos_adv = pos_sum[PW-1:0];
        end
        v_sum = SUMW'($signed(cur_v_reg)) + SUMW'($signed(vstep_reg));
        n_sum = SUMW'($signed(cur_n_reg)) + SUMW'($signed(nstep_reg));
        if (v_sum > SUMW'(8388607)) begin
            v_sat = 24'h7fffff;
        end else if (v_sum < -SUMW'(8388608)) begin
            v_sat = 24'h800000;
        end else begin
            v_sat = v_sum[RATE_W-1:0];
        end
        if (n_sum > SUMW'(8388607)) begin
            n_sat = 24'h7fffff;
        end else if (n_sum < -SUMW'(8388608)) begin
            n_sat = 24'h800000;
        end else begin
            n_sat = n_sum[RATE_W-1:0];
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [16:0]       div_trial;
    logic              div_ge;
    logic [16:0]       div_diff;
    logic [DIV_N-1:0]  div_quo_n;
    logic [RATE_W:0]   div_res;
    logic [RATE_W:0]   ramp_dv, ramp_dn_mag, ramp_dv_mag;

    always_comb begin
        div_trial = {div_rem_reg, div_quo_reg[DIV_N-1]};
        div_ge    = (div_trial >= {1'b0, div_n_reg});
        div_diff  = div_trial - {1'b0, div_n_reg};
        div_quo_n = {div_quo_reg[DIV_N-2:0], div_ge};
        div_res   = div_neg_reg ? -{1'b0, div_quo_n} : {1'b0, div_quo_n};
        ramp_dv   = (RATE_W+1)'($signed(in_tv)) - (RATE_W+1)'($signed(in_sv));
        ramp_dv_mag = ramp_dv[RATE_W] ? -ramp_dv : ramp_dv;
        ramp_dn_mag = dn_diff_reg[RATE_W] ? -dn_diff_reg : dn_diff_reg;
    end

    // position frame of the result
    logic [EW-1:0]     posf_e;
    logic [POSF_W-1:0] posf_w;
    always_comb begin
        posf_e = EW'(pos_reg[PW-1:F]);
        posf_w = (posf_e > EW'(131071)) ? '1 : posf_e[POSF_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_reg      <= TRACK_W'(1);
            loop_en_reg    <= 1'b0;
            loop_start_reg <= '0;
            loop_end_reg   <= TRACK_W'(1);
            pitch_reg      <= RATE_W'(65536);
            gain_reg       <= GAIN_W'(16384);
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            cur_v_reg      <= '0;
            cur_n_reg      <= '0;
            vstep_reg      <= '0;
            nstep_reg      <= '0;
            playing_reg    <= 1'b1;
            m_valid_reg    <= 1'b0;
            rd_cnt_reg     <= '0;
            ch_reg         <= 1'b0;
            div_cnt_reg    <= '0;
            div_sel_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_TRACK_FRAMES: track_reg      <= cfg_wdata[TRACK_W-1:0];
                    CFG_LOOP_ENABLE:  loop_en_reg    <= cfg_wdata[0];
                    CFG_LOOP_START:   loop_start_reg <= cfg_wdata[ADDR_W-1:0];
                    CFG_LOOP_END:     loop_end_reg   <= cfg_wdata[TRACK_W-1:0];
                    CFG_PITCH_RATE:   pitch_reg      <= cfg_wdata[RATE_W-1:0];
                    CFG_OUT_GAIN:     gain_reg       <= cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            // the output stage refills the register itself
            if (m_valid_reg && m_tready && state_reg != S_OUTW) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (s_tuser)
                            OP_RAMP: begin
                                cur_v_reg   <= in_sv;
                                cur_n_reg   <= in_sn;
                                dn_diff_reg <= (RATE_W+1)'($signed(in_tn))
                                             - (RATE_W+1)'($signed(in_sn));
                                div_n_reg   <= (in_count == '0) ? 16'd1 : in_count;
                                div_neg_reg <= ramp_dv[RATE_W];
                                div_quo_reg <= ramp_dv_mag[DIV_N-1:0];
                                div_rem_reg <= '0;
                                div_cnt_reg <= '0;
                                div_sel_reg <= 1'b0;
                                state_reg   <= S_DIV;
                            end
                            OP_SEEK: begin
                                playing_reg <= 1'b1;
                                if (seek_e > EW'({IW{1'b1}})) begin
                                    pos_reg <= '1;
                                end else begin
                                    pos_reg <= {seek_w, {F{1'b0}}};
                                end
                            end
                            OP_RENDER: begin
                                if (past_end && !loop_en_reg) begin
                                    playing_reg <= 1'b0;
                                    pos_reg     <= {end_w, {F{1'b0}}};
                                    res_l_reg   <= '0;
                                    res_r_reg   <= '0;
                                    state_reg   <= S_OUTW;
                                end else begin
                                    pos_reg        <= {base_idx, base_f};
                                    f_reg          <= base_f;
                                    rd_addr_reg[0] <= i0_w[A-1:0];
                                    rd_addr_reg[1] <= base_idx[A-1:0];
                                    rd_addr_reg[2] <= i2_w[A-1:0];
                                    rd_addr_reg[3] <= i3_w[A-1:0];
                                    rd_cnt_reg     <= '0;
                                    ch_reg         <= 1'b0;
                                    state_reg      <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    // read data is registered and arrives in the cycle after its address
                    if (rd_cnt_reg != '0) begin
                        p_reg[rd_cnt_reg[1:0] - 2'd1] <= ram_rdata;
                    end
                    if (rd_cnt_reg == 3'd4) begin
                        state_reg <= S_COEF;
                    end else begin
                        rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    end
                end
                S_COEF: begin
                    c1_reg    <= s2 - s0;
                    c2_reg    <= (s0 <<< 1) - ((s1 <<< 2) + s1) + (s2 <<< 2) - s3;
                    c3_reg    <= (s3 - s0) + ((s1 - s2) <<< 1) + (s1 - s2);
                    tp1_reg   <= s1 <<< 1;
                    state_reg <= S_M1;
                end
                S_M1: begin
                    prod_reg  <= mul_a * $signed({1'b0, mul_b});
                    state_reg <= S_M2;
                end
                S_M2: begin
                    prod_reg  <= mul_a * $signed({1'b0, mul_b});
                    state_reg <= S_M3;
                end
                S_M3: begin
                    prod_reg  <= mul_a * $signed({1'b0, mul_b});
                    state_reg <= S_M4;
                end
                S_M4: begin
                    prod_reg  <= mul_a * $signed({1'b0, mul_b});
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (ch_reg) begin
                        res_r_reg <= y_sat;
                        state_reg <= S_ADV;
                    end else begin
                        res_l_reg <= y_sat;
                        ch_reg    <= 1'b1;
                        state_reg <= S_COEF;
                    end
                end
                S_ADV: begin
                    pos_reg   <= pos_adv;
                    cur_v_reg <= v_sat;
                    cur_n_reg <= n_sat;
                    state_reg <= S_OUTW;
                end
                S_OUTW: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, posf_w, playing_reg, res_r_reg, res_l_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_cnt_reg == 5'(DIV_N - 1)) begin
                        div_cnt_reg <= '0;
                        div_rem_reg <= '0;
                        if (div_sel_reg) begin
                            nstep_reg <= div_res;
                            state_reg <= S_IDLE;
                        end else begin
                            vstep_reg   <= div_res;
                            div_sel_reg <= 1'b1;
                            div_neg_reg <= dn_diff_reg[RATE_W];
                            div_quo_reg <= ramp_dn_mag[DIV_N-1:0];
                        end
                    end else begin
                        div_rem_reg <= div_ge ? div_diff[15:0] : div_trial[15:0];
                        div_quo_reg <= div_quo_n;
                        div_cnt_reg <= div_cnt_reg + 5'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_n_reg != '0))
        else $error("divider runs with a zero divisor");

    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == OP_RENDER) |=> !s_tready)
        else $error("render transfer did not hold off the input");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUTW && m_valid_reg && !m_tready) |=> (state_reg == S_OUTW))
        else $error("result overwrote a pending transfer");

    a_rd_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (rd_cnt_reg <= 3'd4))
        else $error("read sequencer ran past four neighbors");
`endif

endmodule

[tb/tb_hermite_resampler_with_ramp.sv]
`timescale 1ns / 1ps
module tb_hermite_resampler_with_ramp;
    import hrr_pkg::*;

    localparam longint POS_LIMIT = (longint'(1) << 33) - 1;
    localparam int     DEPTH     = 1 << 16;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic [RATE_W-1:0]   sv;
        logic [RATE_W-1:0]   tv;
        logic [RATE_W-1:0]   sn;
        logic [RATE_W-1:0]   tn;
        logic [COUNT_W-1:0]  count;
    } cmd_t;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                playing;
        logic [POSF_W-1:0]   posf;
    } frame_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    hermite_resampler_with_ramp dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow state of the resampler
    logic [31:0] store_mem [DEPTH];
    bit          store_valid [DEPTH];
    longint      pos_q, vel_q, nudge_q, vel_step_q, nudge_step_q;
    bit          playing_q;
    longint      trk_frames, lp_en, lp_start, lp_end, pitch_q, gain_q;

    cmd_t       cmd_queue[$];
    frame_out_t frame_queue[$];
    int         errors = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         hold_left = 0;

    function automatic longint clamp(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sext24(logic [RATE_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint cur_end();
        longint e;
        e = lp_en != 0 ? lp_end : trk_frames;
        return clamp(e, 1, DEPTH);
    endfunction

    // frame index a render will start from, -1 when it stops without reading
    function automatic longint render_index();
        longint e, idx;
        e = cur_end();
        idx = (pos_q < 0 ? 0 : pos_q) >>> 16;
        if (idx >= e && lp_en == 0) return -1;
        if (idx >= e) idx = lp_start >= e ? e - 1 : lp_start;
        return idx;
    endfunction

    function automatic logic [15:0] interp(longint p0, longint p1, longint p2, longint p3,
                                           longint f);
        longint c1, c2, c3, t, y;
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = (p3 - p0) + 3 * (p1 - p2);
        t = ((c3 * f) >>> 16) + c2;
        t = ((t * f) >>> 16) + c1;
        t = (t * f) >>> 16;
        y = ((2 * p1 + t) * gain_q + (longint'(1) << 14)) >>> 15;
        y = clamp(y, -32768, 32767);
        return y[15:0];
    endfunction

    function automatic longint chan(longint i, bit right);
        logic [31:0] w;
        w = store_mem[i];
        return right ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
    endfunction

    task automatic predict_render();
        frame_out_t r;
        longint e, idx, f, i0, i2, i3;
        e = cur_end();
        if (pos_q < 0) pos_q = 0;
        idx = pos_q >>> 16;
        f = pos_q & 64'hFFFF;
        r.left = '0;
        r.right = '0;
        if (idx >= e && lp_en == 0) begin
            playing_q = 1'b0;
            pos_q = e << 16;
        end else begin
            if (idx >= e) begin
                idx = lp_start >= e ? e - 1 : lp_start;
                pos_q = idx << 16;
                f = 0;
            end
            i0 = idx > 0 ? idx - 1 : 0;
            i2 = idx + 1 < e ? idx + 1 : e - 1;
            i3 = idx + 2 < e ? idx + 2 : e - 1;
            r.left = interp(chan(i0, 0), chan(idx, 0), chan(i2, 0), chan(i3, 0), f);
            r.right = interp(chan(i0, 1), chan(idx, 1), chan(i2, 1), chan(i3, 1), f);
            pos_q = clamp(pos_q + pitch_q + nudge_q + vel_q, 0, POS_LIMIT);
            vel_q = clamp(vel_q + vel_step_q, -8388608, 8388607);
            nudge_q = clamp(nudge_q + nudge_step_q, -8388608, 8388607);
        end
        r.playing = playing_q;
        r.posf = POSF_W'(clamp(pos_q >>> 16, 0, 131071));
        frame_queue.push_back(r);
    endtask

    task automatic apply_cmd(cmd_t c);
        longint n;
        case (c.op)
            OP_WRITE: begin
                store_mem[c.addr] = {c.right, c.left};
                store_valid[c.addr] = 1'b1;
            end
            OP_RAMP: begin
                n = c.count == 0 ? 1 : longint'(c.count);
                vel_q = sext24(c.sv);
                nudge_q = sext24(c.sn);
                vel_step_q = (sext24(c.tv) - sext24(c.sv)) / n;
                nudge_step_q = (sext24(c.tn) - sext24(c.sn)) / n;
            end
            OP_SEEK: begin
                pos_q = longint'(c.addr) << 16;
                playing_q = 1'b1;
            end
            default: predict_render();
        endcase
        cmd_queue.push_back(c);
    endtask

    function automatic cmd_t rand_cmd(logic [OP_W-1:0] op);
        cmd_t c;
        c.op = op;
        c.addr = ADDR_W'($urandom);
        c.left = SAMPLE_W'($urandom);
        c.right = SAMPLE_W'($urandom);
        c.sv = RATE_W'($urandom);
        c.tv = RATE_W'($urandom);
        c.sn = RATE_W'($urandom);
        c.tn = RATE_W'($urandom);
        c.count = COUNT_W'($urandom);
        return c;
    endfunction

    task automatic write_frame(longint a, logic [15:0] l, logic [15:0] r);
        cmd_t c;
        c = rand_cmd(OP_WRITE);
        c.addr = a[15:0];
        c.left = l;
        c.right = r;
        apply_cmd(c);
    endtask

    // fill in any neighbor the next render would read before it was written
    task automatic render();
        longint idx, e, k;
        idx = render_index();
        e = cur_end();
        if (idx >= 0) begin
            for (k = idx - 1; k <= idx + 2; k++) begin
                if (k >= 0 && k < e && !store_valid[k])
                    write_frame(k, 16'($urandom), 16'($urandom));
            end
        end
        apply_cmd(rand_cmd(OP_RENDER));
    endtask

    task automatic seek(logic [15:0] a);
        cmd_t c;
        c = rand_cmd(OP_SEEK);
        c.addr = a;
        apply_cmd(c);
    endtask

    task automatic ramp(longint sv, longint tv, longint sn, longint tn, logic [15:0] n);
        cmd_t c;
        c = rand_cmd(OP_RAMP);
        c.sv = sv[23:0];
        c.tv = tv[23:0];
        c.sn = sn[23:0];
        c.tn = tn[23:0];
        c.count = n;
        apply_cmd(c);
    endtask

    function automatic longint small_rate();
        return longint'($urandom_range(0, 131072)) - 65536;
    endfunction

    task automatic wait_idle();
        while (cmd_queue.size() > 0 || s_tvalid || frame_queue.size() > 0)
            @(posedge aclk);
        // a ramp may still be dividing after the last frame came back
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, longint v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TRACK_FRAMES: trk_frames = v & 64'h1FFFF;
            CFG_LOOP_ENABLE:  lp_en = v & 1;
            CFG_LOOP_START:   lp_start = v & 64'hFFFF;
            CFG_LOOP_END:     lp_end = v & 64'h1FFFF;
            CFG_PITCH_RATE:   pitch_q = sext24(v[23:0]);
            default:          gain_q = v & 64'hFFFF;
        endcase
    endtask

    task automatic set_all(longint trk, longint en, longint ls, longint le, longint pr,
                           longint g);
        set_reg(CFG_TRACK_FRAMES, trk);
        set_reg(CFG_LOOP_ENABLE, en);
        set_reg(CFG_LOOP_START, ls);
        set_reg(CFG_LOOP_END, le);
        set_reg(CFG_PITCH_RATE, pr);
        set_reg(CFG_OUT_GAIN, g);
    endtask

    task automatic random_item();
        int pick;
        cmd_t c;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            render();
        end else if (pick < 68) begin
            c = rand_cmd(OP_WRITE);
            if ($urandom_range(0, 7) != 0) c.addr = ADDR_W'($urandom_range(0, 127));
            apply_cmd(c);
        end else if (pick < 84) begin
            seek($urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 90)));
        end else if ($urandom_range(0, 7) == 0) begin
            apply_cmd(rand_cmd(OP_RAMP));
        end else begin
            ramp(small_rate(), small_rate(), small_rate(), small_rate(),
                 16'($urandom_range(0, 40)));
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // input side driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                cmd_t c;
                c = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= c.op;
                s_tdata <= {c.count, c.tn, c.sn, c.tv, c.sv, c.right, c.left, c.addr};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_queue.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                frame_out_t w;
                w = frame_queue.pop_front();
                if (m_tdata[15:0] !== w.left)
                    report_mismatch("out_left", $signed(m_tdata[15:0]), $signed(w.left));
                if (m_tdata[31:16] !== w.right)
                    report_mismatch("out_right", $signed(m_tdata[31:16]), $signed(w.right));
                if (m_tdata[32] !== w.playing)
                    report_mismatch("is_playing", m_tdata[32], w.playing);
                if (m_tdata[49:33] !== w.posf)
                    report_mismatch("position_frame", m_tdata[49:33], w.posf);
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= recv_idle;
        end
    end

    initial begin
        pos_q = 0; vel_q = 0; nudge_q = 0; vel_step_q = 0; nudge_step_q = 0;
        playing_q = 1'b1;
        trk_frames = 1; lp_en = 0; lp_start = 0; lp_end = 1; pitch_q = 65536; gain_q = 16384;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_idle = 36;
        recv_idle = 53;
        // directed: extremes, saturation, zero ramp count, end of track
        set_all(8, 0, 0, 8, 32768, 65535);
        write_frame(0, 16'h7FFF, 16'h8000);
        write_frame(1, 16'h8000, 16'h7FFF);
        write_frame(2, 16'h7FFF, 16'h8000);
        write_frame(3, 16'h0000, 16'hFFFF);
        render();
        render();
        render();
        ramp(0, 65536, 0, -65536, 0);
        render();
        ramp(8388607, -8388608, -8388608, 8388607, 65535);
        render();
        render();
        ramp(-8388608, -8388608, 0, 0, 1);
        render();
        render();
        seek(16'd7);
        render();
        render();
        render();
        seek(16'hFFFF);
        render();
        seek(16'd0);
        ramp(0, 0, 0, 0, 1);
        render();
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                send_idle = 53;
                recv_idle = 36;
            end else if (ph == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (ph)
                0: set_all(64, 0, 0, 64, 65536 + $urandom_range(0, 40000), 16384);
                1: set_all(64, 1, 10, 40, 98304, 20000);
                2: set_all(64, 1, 65535, 0, 70000, 32768);
                3: set_all(65536, 0, 0, 1, -8388608, 16384);
                4: set_all(65536, 1, 65530, 65536, 8388607, 0);
                5: set_all(0, 0, 0, 1, 40000, 65535);
                6: set_all(100, 1, 5, 131071, 90000, 12000);
                default: set_all(50, 0, 0, 50, 50000, 16384);
            endcase
            if (ph == 1) begin
                // receiver stalls long while the sender keeps offering frames
                for (int k = 0; k < 20; k++) render();
                hold_left = 400;
            end
            for (int k = 0; k < 80; k++) random_item();
            wait_idle();
        end
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
rtl/hrr_pkg.sv
rtl/hrr_ram.sv
rtl/hermite_resampler_with_ramp.sv
tb/tb_hermite_resampler_with_ramp.sv
